// ===== hdl/olrb_pkg.sv =====
// Shared constants, command codes and pointer helper for the overwrite log ring.
// No dependencies.
package olrb_pkg;

	localparam int DEPTH = 1024;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int BYTE_W = 8;
	localparam int CMD_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REWIND = 2'd3;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// ===== hdl/overwrite_log_ring_buffer.sv =====
// Overwrite-oldest byte log ring: top level.
// Depends on olrb_pkg and olrb_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: cmd and in_byte.
//   put appends in_byte; on a full ring (DEPTH-1 bytes held) the oldest byte is
//   dropped first and dropped is flagged. get consumes the oldest byte, read
//   returns the reader's next byte without consuming, rewind moves the reader
//   back to the oldest byte.
//   Result channel (result_valid/result_ready) carries exactly one beat per
//   command: out_byte, out_valid and dropped. out_byte is zero unless out_valid.
//   Path: the edge that takes a command loads the registered RAM read; the read
//   stage then moves into the result register, which presents the result beat,
//   once that register is free.
//   Throughput: one command per cycle while the receiver does not stall, set by the single RAM access per command.
//   When the receiver stalls, the result register and the read stage hold and
//   in_ready drops once both are occupied; nothing is lost.
//   Reset clears all three pointers (empty ring); stored bytes are not cleared.
module overwrite_log_ring_buffer
	import olrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_valid,
	output logic              dropped
);

	logic [PTR_W-1:0] wr_q, cons_q, rd_q;
	logic [PTR_W-1:0] wr_d, cons_d, rd_d;
	logic [PTR_W-1:0] raddr;
	logic             accept, out_free;
	logic             we_c, ov_c, dr_c, full;
	logic             v_s1, ov_s1, dr_s1;
	logic [BYTE_W-1:0] rdata;
	logic             result_valid_q, out_valid_q, dropped_q;
	logic [BYTE_W-1:0] out_byte_q;

	assign out_free = !result_valid_q || result_ready;
	assign in_ready = !v_s1 || out_free;
	assign accept   = in_valid && in_ready;
	assign full     = (ptr_next(wr_q) == cons_q);

	always_comb begin
		wr_d   = wr_q;
		cons_d = cons_q;
		rd_d   = rd_q;
		raddr  = cons_q;
		we_c   = 1'b0;
		ov_c   = 1'b0;
		dr_c   = 1'b0;
		unique case (cmd)
			CMD_PUT: begin
				we_c = 1'b1;
				wr_d = ptr_next(wr_q);
				if (full) begin
					dr_c   = 1'b1;
					cons_d = ptr_next(cons_q);
					// reader sat on the dropped slot: drag it along
					if (rd_q == cons_q) begin
						rd_d = ptr_next(cons_q);
					end
				end
			end
			CMD_GET: begin
				if (wr_q != cons_q) begin
					ov_c   = 1'b1;
					cons_d = ptr_next(cons_q);
				end
			end
			CMD_READ: begin
				raddr = rd_q;
				if (wr_q != rd_q) begin
					ov_c = 1'b1;
					rd_d = ptr_next(rd_q);
				end
			end
			CMD_REWIND: begin
				rd_d = cons_q;
			end
			default: begin
			end
		endcase
	end

	olrb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && we_c),
		.waddr(wr_q),
		.wdata(in_byte),
		.re   (accept && ov_c),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q           <= '0;
			cons_q         <= '0;
			rd_q           <= '0;
			v_s1           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				wr_q   <= wr_d;
				cons_q <= cons_d;
				rd_q   <= rd_d;
				v_s1   <= 1'b1;
			end else if (out_free) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ov_s1 <= ov_c;
			dr_s1 <= dr_c;
		end
		if (v_s1 && out_free) begin
			out_byte_q  <= ov_s1 ? rdata : '0;
			out_valid_q <= ov_s1;
			dropped_q   <= dr_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign out_byte     = out_byte_q;
	assign out_valid    = out_valid_q;
	assign dropped      = dropped_q;

`ifndef NO_ASSERTIONS
	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && result_valid_q && !result_ready) |-> !in_ready)
		else $error("command taken while read stage is blocked");

	a_result_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(out_valid && dropped))
		else $error("result carries both a byte and a drop");

	a_zero_byte_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !out_valid) |-> (out_byte == '0))
		else $error("nonzero byte without out_valid");

	a_drop_advances_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_PUT && full) |=> (cons_q == ptr_next($past(cons_q))))
		else $error("overwrite did not advance the consume pointer");

	a_result_follows_command: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_free) |=> result_valid)
		else $error("read stage drained without a result beat");
`endif

endmodule

// ===== hdl/olrb_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module olrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
